/* rtl/gslp_pkg.sv */
// ----------------------------------------------------------------------------
// gslp_pkg: shared types and constants
// Command codes, coordinate widths and the line request passed from the
// event front end to the line stepper.
// ----------------------------------------------------------------------------
package gslp_pkg;

  localparam int COORD_W = 5;
  localparam int CMD_W   = 2;
  localparam int CNT_W   = 6;
  localparam int ERR_W   = 12;
  localparam int YPOS_W  = 8;

  localparam logic [CMD_W-1:0] CMD_PRESS   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MOVE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  localparam logic [CNT_W-1:0] MAX_WRITES = 6'd62;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic   point;
    coord_t x0;
    coord_t y0;
    coord_t tx;
    coord_t ty;
    logic   value;
  } job_t;

endpackage

/* rtl/gslp_front.sv */
// ----------------------------------------------------------------------------
// gslp_front: pointer event front end
// Holds the stroke anchor and paint value, and turns press and move events
// into line requests for the stepper.
// ----------------------------------------------------------------------------
module gslp_front
  import gslp_pkg::*;
#(
  parameter int GRID_COLS = 32,
  parameter int GRID_ROWS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [15:0]        s_tdata,   // cell_x, cell_y, cell_valid, left_only, current_value
  input  logic [CMD_W-1:0]   s_tuser,   // cmd
  input  logic               job_full,
  output logic               job_push,
  output job_t               job
);

  localparam coord_t MAX_X = COORD_W'(GRID_COLS - 1);
  localparam coord_t MAX_Y = COORD_W'(GRID_ROWS - 1);

  logic   anchor_valid;
  coord_t anchor_x;
  coord_t anchor_y;
  logic   paint_value;

  coord_t cx, cy, tx, ty;
  logic   cell_valid, left_only, current_value;
  logic   accept, press_ok, move_ok;

  assign cx            = s_tdata[4:0];
  assign cy            = s_tdata[9:5];
  assign cell_valid    = s_tdata[10];
  assign left_only     = s_tdata[11];
  assign current_value = s_tdata[12];

  assign tx = (cx > MAX_X) ? MAX_X : cx;
  assign ty = (cy > MAX_Y) ? MAX_Y : cy;

  assign s_tready = !job_full;
  assign accept   = s_tvalid && s_tready;

  assign press_ok = (s_tuser == CMD_PRESS) && left_only && cell_valid &&
                    (cx <= MAX_X) && (cy <= MAX_Y);
  assign move_ok  = (s_tuser == CMD_MOVE) && anchor_valid;

  always_comb begin
    job_push = 1'b0;
    job      = '0;
    if (press_ok) begin
      job.point = 1'b1;
      job.x0    = cx;
      job.y0    = cy;
      job.tx    = cx;
      job.ty    = cy;
      job.value = !current_value;
      job_push  = accept;
    end else if (move_ok) begin
      job.point = 1'b0;
      job.x0    = anchor_x;
      job.y0    = anchor_y;
      job.tx    = tx;
      job.ty    = ty;
      job.value = paint_value;
      job_push  = accept && ((tx != anchor_x) || (ty != anchor_y));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_valid <= 1'b0;
      anchor_x     <= '0;
      anchor_y     <= '0;
      paint_value  <= 1'b0;
    end else if (accept) begin
      if (press_ok) begin
        anchor_valid <= 1'b1;
        anchor_x     <= cx;
        anchor_y     <= cy;
        paint_value  <= !current_value;
      end else if (move_ok) begin
        anchor_x <= tx;
        anchor_y <= ty;
      end else if (s_tuser == CMD_RELEASE) begin
        anchor_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/gslp_queue.sv */
// ----------------------------------------------------------------------------
// gslp_queue: line request queue
// Two-entry first-in first-out buffer between the front end and the stepper.
// ----------------------------------------------------------------------------
module gslp_queue
  import gslp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t pop_job
);

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* rtl/gslp_back.sv */
// ----------------------------------------------------------------------------
// gslp_back: line stepper
// Takes one line request at a time and emits its cell writes, one per
// cycle while the receiver is not stalling, through the output register.
// ----------------------------------------------------------------------------
module gslp_back
  import gslp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,    // write_x, write_y, write_value
  output logic        m_tlast
);

  localparam logic       ST_IDLE  = 1'b0;
  localparam logic       ST_RUN   = 1'b1;
  localparam logic [1:0] PH_POINT = 2'd0;
  localparam logic [1:0] PH_XSTEP = 2'd1;
  localparam logic [1:0] PH_YSTEP = 2'd2;

  logic                     state;
  logic [1:0]               phase;
  coord_t                   x, tx;
  logic signed [YPOS_W-1:0] y, ty_s;
  logic signed [ERR_W-1:0]  err, adx_s, adx2, ady2;
  logic                     sx_neg, sy_neg, value;
  logic [CNT_W-1:0]         n;

  coord_t                   out_x, out_y;
  logic                     out_value, out_last;

  coord_t                   adx_ld, ady_ld;
  logic signed [ERR_W-1:0]  adx_ld_s, ady_ld2;

  logic                     out_free, step, last;
  logic [1:0]               phase_next;
  coord_t                   x_next;
  logic signed [YPOS_W-1:0] y_next, y_step;
  logic signed [ERR_W-1:0]  err_add, err_next;
  logic [CNT_W-1:0]         n_inc;
  logic                     cap_hit;

  assign out_free = !m_tvalid || m_tready;
  assign step     = (state == ST_RUN) && out_free;
  assign job_pop  = (state == ST_IDLE) && job_valid;

  assign adx_ld   = (job.x0 > job.tx) ? job.x0 - job.tx : job.tx - job.x0;
  assign ady_ld   = (job.y0 > job.ty) ? job.y0 - job.ty : job.ty - job.y0;
  assign adx_ld_s = $signed({{(ERR_W-COORD_W){1'b0}}, adx_ld});
  assign ady_ld2  = $signed({{(ERR_W-COORD_W-1){1'b0}}, ady_ld, 1'b0});

  assign n_inc   = n + 1'b1;
  assign cap_hit = (n_inc == MAX_WRITES);
  assign y_step  = sy_neg ? y - YPOS_W'(1) : y + YPOS_W'(1);
  assign err_add = err + ady2;

  always_comb begin
    phase_next = phase;
    x_next     = x;
    y_next     = y;
    err_next   = err;
    last       = 1'b1;
    unique case (phase)
      PH_POINT: begin
        last = 1'b1;
      end
      PH_XSTEP: begin
        x_next = sx_neg ? x - 1'b1 : x + 1'b1;
        if (err_add >= adx_s) begin
          y_next   = y_step;
          err_next = err_add - adx2;
        end else begin
          err_next = err_add;
        end
        if (cap_hit) begin
          last = 1'b1;
        end else if (x_next == tx) begin
          phase_next = PH_YSTEP;
          last       = (y_next == ty_s);
        end else begin
          last = 1'b0;
        end
      end
      PH_YSTEP: begin
        y_next = y_step;
        last   = cap_hit || (y_next == ty_s);
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (step) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (job_pop) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (step && last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      x      <= job.x0;
      y      <= $signed({{(YPOS_W-COORD_W){1'b0}}, job.y0});
      tx     <= job.tx;
      ty_s   <= $signed({{(YPOS_W-COORD_W){1'b0}}, job.ty});
      sx_neg <= !(job.x0 < job.tx);
      sy_neg <= !(job.y0 < job.ty);
      adx_s  <= adx_ld_s;
      adx2   <= adx_ld_s <<< 1;
      ady2   <= ady_ld2;
      err    <= ady_ld2 - adx_ld_s;
      n      <= '0;
      value  <= job.value;
      if (job.point) begin
        phase <= PH_POINT;
      end else if (adx_ld != '0) begin
        phase <= PH_XSTEP;
      end else begin
        phase <= PH_YSTEP;
      end
    end else if (step) begin
      x     <= x_next;
      y     <= y_next;
      err   <= err_next;
      n     <= n_inc;
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_x     <= x;
      out_y     <= y[COORD_W-1:0];
      out_value <= value;
      out_last  <= last;
    end
  end

  assign m_tdata = {5'b0, out_value, out_y, out_x};
  assign m_tlast = out_last;

endmodule

/* rtl/grid_stroke_line_painter.sv */
// ----------------------------------------------------------------------------
// grid_stroke_line_painter: stroke painter for a cell grid
// Turns pointer press, move and release events into cell write requests.
// ----------------------------------------------------------------------------
// A press (cmd 0) with only the left button on a valid cell writes that cell
// with the inverse of its current state and anchors the stroke; a move (cmd 1)
// writes the cells of a line from the anchor up to, not including, the new
// cell, which becomes the anchor; a release (cmd 2) ends the stroke. Events
// are taken in one cycle each while the two-entry request queue has room. The
// line stepper loads a request and then emits one cell write per cycle while
// the output is not stalled; a move gives at most 62 writes and a press one;
// m_tlast marks the final write of each event.
module grid_stroke_line_painter
  import gslp_pkg::*;
#(
  parameter int GRID_COLS = 32,
  parameter int GRID_ROWS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [15:0]        s_tdata,   // cell_x, cell_y, cell_valid, left_only, current_value
  input  logic [CMD_W-1:0]   s_tuser,   // cmd
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [15:0]        m_tdata,   // write_x, write_y, write_value
  output logic               m_tlast
);

  job_t push_job, pop_job;
  logic job_push, job_pop, q_full, q_empty;

  gslp_front #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .job_full (q_full),
    .job_push (job_push),
    .job      (push_job)
  );

  gslp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (job_pop),
    .empty    (q_empty),
    .pop_job  (pop_job)
  );

  gslp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!q_empty),
    .job       (pop_job),
    .job_pop   (job_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> !q_empty)
    else $error("line request taken from empty queue");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    job_push |-> !q_full)
    else $error("line request pushed into full queue");

  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty))
    else $error("queue both full and empty");
`endif

endmodule

/* tb/grid_stroke_line_painter_tb.sv */
// ----------------------------------------------------------------------------
// grid_stroke_line_painter_tb: self-checking bench for the stroke painter
// Drives pointer press, move and release requests: first a short table of
// directed events, then random strokes mixed with noise. A built-in line
// predictor tracks the stroke state and expects every cell write in order.
// The sender idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module grid_stroke_line_painter_tb;
  import gslp_pkg::*;

  localparam int COLS = 32;
  localparam int ROWS = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int STROKE_TARGET = 110;
  localparam int TAIL_CYCLES = 40;
  localparam int NO_TYPED = -1;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   value;
    logic   last;
  } cell_write_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    coord_t           x;
    coord_t           y;
    logic             valid;
    logic             left;
    logic             cur;
    int               known_writes;
    coord_t           wx;
    coord_t           wy;
    logic             wv;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [21] = '{
    '{CMD_MOVE,    5'd31, 5'd31, 1'b1, 1'b1, 1'b0, 0,        5'd0,  5'd0,  1'b0},
    '{CMD_RELEASE, 5'd31, 5'd31, 1'b1, 1'b1, 1'b1, 0,        5'd0,  5'd0,  1'b0},
    '{CMD_PRESS,   5'd31, 5'd0,  1'b1, 1'b0, 1'b0, 0,        5'd0,  5'd0,  1'b0},
    '{CMD_PRESS,   5'd0,  5'd31, 1'b0, 1'b1, 1'b1, 0,        5'd0,  5'd0,  1'b0},
    '{CMD_PRESS,   5'd0,  5'd0,  1'b1, 1'b1, 1'b0, 1,        5'd0,  5'd0,  1'b1},
    '{CMD_MOVE,    5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 0,        5'd0,  5'd0,  1'b0},
    '{CMD_MOVE,    5'd31, 5'd31, 1'b1, 1'b1, 1'b1, NO_TYPED, 5'd0,  5'd0,  1'b0},
    '{CMD_MOVE,    5'd0,  5'd31, 1'b0, 1'b1, 1'b0, NO_TYPED, 5'd0,  5'd0,  1'b0},
    '{CMD_MOVE,    5'd0,  5'd0,  1'b1, 1'b0, 1'b1, NO_TYPED, 5'd0,  5'd0,  1'b0},
    '{CMD_MOVE,    5'd31, 5'd5,  1'b0, 1'b0, 1'b0, NO_TYPED, 5'd0,  5'd0,  1'b0},
    '{CMD_MOVE,    5'd30, 5'd31, 1'b1, 1'b1, 1'b0, NO_TYPED, 5'd0,  5'd0,  1'b0},
    '{CMD_UNUSED,  5'd7,  5'd9,  1'b1, 1'b1, 1'b1, 0,        5'd0,  5'd0,  1'b0},
    '{CMD_PRESS,   5'd31, 5'd31, 1'b1, 1'b1, 1'b1, 1,        5'd31, 5'd31, 1'b0},
    '{CMD_MOVE,    5'd31, 5'd0,  1'b0, 1'b1, 1'b1, NO_TYPED, 5'd0,  5'd0,  1'b0},
    '{CMD_MOVE,    5'd0,  5'd1,  1'b1, 1'b0, 1'b0, NO_TYPED, 5'd0,  5'd0,  1'b0},
    '{CMD_RELEASE, 5'd21, 5'd10, 1'b0, 1'b0, 1'b0, 0,        5'd0,  5'd0,  1'b0},
    '{CMD_MOVE,    5'd10, 5'd21, 1'b1, 1'b1, 1'b1, 0,        5'd0,  5'd0,  1'b0},
    '{CMD_PRESS,   5'd15, 5'd16, 1'b1, 1'b1, 1'b1, 1,        5'd15, 5'd16, 1'b0},
    '{CMD_MOVE,    5'd16, 5'd16, 1'b0, 1'b0, 1'b1, NO_TYPED, 5'd0,  5'd0,  1'b0},
    '{CMD_MOVE,    5'd17, 5'd0,  1'b1, 1'b1, 1'b0, NO_TYPED, 5'd0,  5'd0,  1'b0},
    '{CMD_RELEASE, 5'd0,  5'd0,  1'b1, 1'b1, 1'b1, 0,        5'd0,  5'd0,  1'b0}
  };

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [15:0]      s_tdata;   // cell_x, cell_y, cell_valid, left_only, current_value
  logic [CMD_W-1:0] s_tuser;   // cmd
  logic             m_tvalid;
  logic             m_tready;
  logic [15:0]      m_tdata;   // write_x, write_y, write_value
  logic             m_tlast;

  cell_write_t pending_writes [$];
  int          err_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;

  logic   stroke_active = 1'b0;
  coord_t anchor_x = '0;
  coord_t anchor_y = '0;
  logic   paint_value = 1'b0;

  grid_stroke_line_painter #(
    .GRID_COLS(COLS),
    .GRID_ROWS(ROWS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int clamp_coord(input int v, input int limit);
    if (v < 0) return 0;
    if (v > limit - 1) return limit - 1;
    return v;
  endfunction

  // Advance the stroke state for one event; queue its cell writes when asked.
  function automatic void paint_event(input logic [CMD_W-1:0] cmd, input coord_t x,
                                      input coord_t y, input logic valid, input logic left,
                                      input logic cur, input bit record);
    cell_write_t line_q [$];
    cell_write_t w;
    int cx, cy, tx, ty, adx, ady, sx, sy, acc;
    case (cmd)
      CMD_PRESS: begin
        if (left && valid && int'(x) < COLS && int'(y) < ROWS) begin
          stroke_active = 1'b1;
          anchor_x = x;
          anchor_y = y;
          paint_value = ~cur;
          line_q.push_back('{x, y, paint_value, 1'b0});
        end
      end
      CMD_MOVE: begin
        if (stroke_active) begin
          tx = clamp_coord(int'(x), COLS);
          ty = clamp_coord(int'(y), ROWS);
          cx = int'(anchor_x);
          cy = int'(anchor_y);
          adx = (tx > cx) ? tx - cx : cx - tx;
          ady = (ty > cy) ? ty - cy : cy - ty;
          sx = (cx < tx) ? 1 : -1;
          sy = (cy < ty) ? 1 : -1;
          if (adx != 0) begin
            acc = 2 * ady - adx;
            while (cx != tx && line_q.size() < int'(MAX_WRITES)) begin
              line_q.push_back('{coord_t'(cx), coord_t'(cy), paint_value, 1'b0});
              acc += 2 * ady;
              if (acc >= adx) begin
                cy += sy;
                acc -= 2 * adx;
              end
              cx += sx;
            end
          end
          while (cy != ty && line_q.size() < int'(MAX_WRITES)) begin
            line_q.push_back('{coord_t'(cx), coord_t'(cy), paint_value, 1'b0});
            cy += sy;
          end
          anchor_x = coord_t'(tx);
          anchor_y = coord_t'(ty);
        end
      end
      CMD_RELEASE: stroke_active = 1'b0;
      default: ;
    endcase
    if (line_q.size() > 0) begin
      line_q[line_q.size() - 1].last = 1'b1;
    end
    if (record) begin
      foreach (line_q[i]) begin
        w = line_q[i];
        pending_writes.push_back(w);
      end
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_event(input logic [CMD_W-1:0] cmd, input coord_t x, input coord_t y,
                            input logic valid, input logic left, input logic cur,
                            input bit record);
    int gap;
    paint_event(cmd, x, y, valid, left, cur, record);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tuser = cmd;
    s_tdata = {3'b000, cur, left, valid, y, x};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Hold the sender until every expected write has come back.
  task automatic drain_writes();
    s_tvalid = 1'b0;
    burst_left = 0;
    while (pending_writes.size() != 0) @(negedge clk);
  endtask

  initial begin : tready_pattern
    int mode;
    int span;
    m_tready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: m_tready = 1'b1;
          1: m_tready = 1'($urandom_range(0, 1));
          2: m_tready = ($urandom_range(0, 3) != 0);
          default: m_tready = ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_writes
    cell_write_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_writes.size() == 0) begin
        $error("unexpected write x=%0d y=%0d", m_tdata[4:0], m_tdata[9:5]);
        err_count++;
      end else begin
        w = pending_writes.pop_front();
        if (m_tdata[4:0] !== w.x) begin
          $error("write_x expected %0d got %0d", w.x, m_tdata[4:0]);
          err_count++;
        end
        if (m_tdata[9:5] !== w.y) begin
          $error("write_y expected %0d got %0d", w.y, m_tdata[9:5]);
          err_count++;
        end
        if (m_tdata[10] !== w.value) begin
          $error("write_value expected %0d got %0d", w.value, m_tdata[10]);
          err_count++;
        end
        if (m_tlast !== w.last) begin
          $error("last expected %0d got %0d", w.last, m_tlast);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("grid_stroke_line_painter_tb: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t row;
    int stroke_events;
    int moves;
    int pick;
    coord_t tx;
    coord_t ty;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = CMD_PRESS;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      if (row.known_writes == 1) begin
        pending_writes.push_back('{row.wx, row.wy, row.wv, 1'b1});
      end
      send_event(row.cmd, row.x, row.y, row.valid, row.left, row.cur,
                 row.known_writes == NO_TYPED);
    end
    drain_writes();

    stroke_events = 0;
    while (stroke_events < STROKE_TARGET) begin
      if ($urandom_range(0, 9) < 7) begin
        send_event(CMD_PRESS, coord_t'($urandom_range(0, 31)), coord_t'($urandom_range(0, 31)),
                   1'b1, 1'b1, 1'($urandom_range(0, 1)), 1'b1);
        stroke_events++;
        moves = $urandom_range(1, 6);
        repeat (moves) begin
          pick = $urandom_range(0, 9);
          if (pick < 3) begin
            tx = coord_t'($urandom_range(0, 31));
            ty = coord_t'($urandom_range(0, 31));
          end else begin
            tx = coord_t'(clamp_coord(int'(anchor_x) + $urandom_range(0, 8) - 4, COLS));
            ty = coord_t'(clamp_coord(int'(anchor_y) + $urandom_range(0, 8) - 4, ROWS));
          end
          if (pick == 9) begin
            send_event(CMD_PRESS, tx, ty, 1'b1, 1'b1, 1'($urandom_range(0, 1)), 1'b1);
          end else begin
            send_event(CMD_MOVE, tx, ty, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'b1);
          end
          stroke_events++;
        end
        send_event(CMD_RELEASE, coord_t'($urandom), coord_t'($urandom),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'b1);
        stroke_events++;
        if ($urandom_range(0, 7) == 0) drain_writes();
      end else begin
        pick = $urandom_range(0, 3);
        case (pick)
          0: send_event(CMD_PRESS, coord_t'($urandom), coord_t'($urandom),
                        1'($urandom_range(0, 1)), 1'b0, 1'($urandom_range(0, 1)), 1'b1);
          1: send_event(CMD_PRESS, coord_t'($urandom), coord_t'($urandom),
                        1'b0, 1'b1, 1'($urandom_range(0, 1)), 1'b1);
          2: send_event(CMD_UNUSED, coord_t'($urandom), coord_t'($urandom),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), 1'b1);
          default: send_event(CMD_MOVE, coord_t'($urandom), coord_t'($urandom),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'b1);
        endcase
        stroke_events++;
      end
    end

    drain_writes();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (pending_writes.size() != 0) begin
      $error("%0d expected writes never arrived", pending_writes.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("grid_stroke_line_painter_tb: done, clean");
    end else begin
      $display("grid_stroke_line_painter_tb: done, errors");
    end
    $finish;
  end

endmodule
